/* rtl/core/signed_integer_digit_glyph_renderer_defines.svh */
// Assertion macros shared by the glyph renderer RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef SIGNED_INTEGER_DIGIT_GLYPH_RENDERER_DEFINES_SVH
`define SIGNED_INTEGER_DIGIT_GLYPH_RENDERER_DEFINES_SVH

// same-cycle implication
`define SIGR_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SIGR_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sigr_pkg.sv */
// Types, codes and constants for the glyph renderer: beat structs, step and
// microcode word types, and the 3x5 font ROM. No dependencies.
`default_nettype none

package sigr_pkg;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] new_value;
    logic [2:0]         pixel_row;
    logic [4:0]         pixel_column;
  } sigr_in_t;

  typedef struct packed {
    logic [1:0] pixel_class;
    logic [4:0] drawn_width;
    logic       area_reduced;
  } sigr_out_t;

  localparam logic OP_SET   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] CLS_BACKGROUND = 2'd0;
  localparam logic [1:0] CLS_FOREGROUND = 2'd1;
  localparam logic [1:0] CLS_BLANK      = 2'd2;

  localparam int GLYPH_W     = 3;
  localparam int GLYPH_H     = 5;
  localparam int GLYPH_BITS  = GLYPH_W * GLYPH_H;
  localparam int SLOT_W      = GLYPH_W + 1;
  localparam logic [3:0] MINUS_GLYPH = 4'd10;

  // 21 font bytes, byte k at bits [8k+7:8k], LSB first
  localparam int FONT_LEN = 168;
  localparam logic [FONT_LEN-1:0] FONT_ROM =
    168'h00_70_24_F7_FB_EF_92_4F_EF_27_CE_7C_9E_DF_3C_FC_F9_FA_49_FB_6F;

  // floor(x/10) = (x * RECIP_10) >> RECIP_SHIFT for any 32-bit x
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  typedef enum logic [1:0] {
    STEP_IDLE,
    STEP_MUL,
    STEP_DIGIT,
    STEP_FINISH
  } step_t;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_START,
    COND_DIGITS_DONE,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    logic  accept_en;
    logic  mul_en;
    logic  digit_en;
    logic  finish_en;
    cond_t cond;
    step_t next_step;
    step_t jump_step;
  } ucode_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic digit;
    logic finish;
  } dp_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/sigr_ucode_rom.sv */
// Microprogram table of the renderer sequencer: one control word per step.
// Depends on sigr_pkg.
`default_nettype none

module sigr_ucode_rom (
  input  sigr_pkg::step_t  step,
  output sigr_pkg::ucode_t word
);
  import sigr_pkg::*;

  always_comb begin
    unique case (step)
      // wait for a beat; a set-value starts the digit loop
      STEP_IDLE:   word = '{accept_en: 1'b1, mul_en: 1'b0, digit_en: 1'b0,
                            finish_en: 1'b0, cond: COND_START,
                            next_step: STEP_IDLE, jump_step: STEP_MUL};
      STEP_MUL:    word = '{accept_en: 1'b0, mul_en: 1'b1, digit_en: 1'b0,
                            finish_en: 1'b0, cond: COND_NEVER,
                            next_step: STEP_DIGIT, jump_step: STEP_DIGIT};
      STEP_DIGIT:  word = '{accept_en: 1'b0, mul_en: 1'b0, digit_en: 1'b1,
                            finish_en: 1'b0, cond: COND_DIGITS_DONE,
                            next_step: STEP_MUL, jump_step: STEP_FINISH};
      // hold until the output register is free
      STEP_FINISH: word = '{accept_en: 1'b0, mul_en: 1'b0, digit_en: 1'b0,
                            finish_en: 1'b1, cond: COND_OUT_FREE,
                            next_step: STEP_FINISH, jump_step: STEP_IDLE};
      default:     word = '{accept_en: 1'b0, mul_en: 1'b0, digit_en: 1'b0,
                            finish_en: 1'b0, cond: COND_NEVER,
                            next_step: STEP_IDLE, jump_step: STEP_IDLE};
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/sigr_digit_path.sv */
// Digit datapath: magnitude, reciprocal multiplier, digit store, count,
// drawn width and shrink flag. Depends on sigr_pkg and the defines header.
`default_nettype none
`include "signed_integer_digit_glyph_renderer_defines.svh"

module sigr_digit_path #(
  parameter int MAX_DIGITS = 6
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  sigr_pkg::dp_ctrl_t               ctrl,
  input  wire [31:0]                       load_value,
  output logic                             neg,
  output logic [MAX_DIGITS-1:0][3:0]       digits,
  output logic [$clog2(MAX_DIGITS+1)-1:0]  count,
  output logic [$clog2(MAX_DIGITS*4+5)-1:0] width,
  output logic                             shrink,
  output logic                             digits_done,
  output logic [$clog2(MAX_DIGITS*4+5)-1:0] fin_width,
  output logic                             fin_shrink
);
  import sigr_pkg::*;

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int WW = $clog2(MAX_DIGITS * 4 + 5);
  localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int QW = 64 - RECIP_SHIFT;

  logic [31:0]                mag_r;
  logic [QW-1:0]              quo_r;
  logic                       neg_r;
  logic [MAX_DIGITS-1:0][3:0] digits_r;
  logic [CW-1:0]              count_r;
  logic [WW-1:0]              width_r;
  logic                       shrink_r;

  logic [63:0] prod;
  logic [31:0] quo_ext;
  logic [31:0] quo_x10;
  logic [31:0] rem_full;

  assign prod     = 64'(mag_r) * 64'(RECIP_10);
  assign quo_ext  = 32'(quo_r);
  assign quo_x10  = (quo_ext << 3) + (quo_ext << 1);
  assign rem_full = mag_r - quo_x10;

  // last digit when nothing is left above it or the store is full
  assign digits_done = (quo_r == '0) || ((count_r + CW'(1)) == CW'(MAX_DIGITS));

  assign fin_width  = (WW'(count_r) << 2) - WW'(1) + (neg_r ? WW'(SLOT_W) : WW'(0));
  assign fin_shrink = fin_width < width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r    <= 1'b0;
      count_r  <= '0;
      width_r  <= '0;
      shrink_r <= 1'b0;
    end else begin
      if (ctrl.load) begin
        neg_r   <= load_value[31];
        count_r <= '0;
      end
      if (ctrl.digit) begin
        count_r <= count_r + CW'(1);
      end
      if (ctrl.finish) begin
        width_r  <= fin_width;
        shrink_r <= fin_shrink;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag_r <= load_value[31] ? (32'd0 - load_value) : load_value;
    end
    if (ctrl.mul) begin
      quo_r <= prod[63:RECIP_SHIFT];
    end
    if (ctrl.digit) begin
      digits_r[count_r[IW-1:0]] <= rem_full[3:0];
      mag_r                     <= quo_ext;
    end
  end

  assign neg    = neg_r;
  assign digits = digits_r;
  assign count  = count_r;
  assign width  = width_r;
  assign shrink = shrink_r;

  `SIGR_ASSERT_NXT(a_count_range, clk, rst_n, ctrl.digit,
                   (count_r != '0) && (count_r <= CW'(MAX_DIGITS)),
                   "digit count out of range after a digit step")

endmodule

`default_nettype wire

/* rtl/core/sigr_pixel_lookup.sv */
// Pixel query: slot and column decode, digit select and font ROM read.
// Depends on sigr_pkg.
`default_nettype none

module sigr_pixel_lookup #(
  parameter int MAX_DIGITS = 6
) (
  input  wire [2:0]                          row,
  input  wire [4:0]                          col,
  input  wire                                neg,
  input  wire [MAX_DIGITS-1:0][3:0]          digits,
  input  wire [$clog2(MAX_DIGITS+1)-1:0]     count,
  input  wire [$clog2(MAX_DIGITS*4+5)-1:0]   width,
  output logic [1:0]                         pixel_class
);
  import sigr_pkg::*;

  localparam int CW   = $clog2(MAX_DIGITS + 1);
  localparam int WW   = $clog2(MAX_DIGITS * 4 + 5);
  localparam int IW   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CMPW = (WW > 5) ? WW : 5;
  localparam int KW   = (CW > 3) ? CW : 3;

  logic          outside;
  logic [2:0]    slot;
  logic [1:0]    sub;
  logic [KW-1:0] digit_slot;
  logic [KW-1:0] pos;
  logic [3:0]    glyph;
  logic [7:0]    font_idx;
  logic          font_bit;
  logic          is_minus;
  logic          in_digits;

  assign outside    = (CMPW'(col) >= CMPW'(width)) || (row >= 3'(GLYPH_H));
  assign slot       = col[4:2];
  assign sub        = col[1:0];
  assign is_minus   = neg && (slot == 3'd0);
  assign digit_slot = KW'(slot) - KW'(neg);
  assign in_digits  = digit_slot < KW'(count);
  // leftmost glyph is the most significant kept digit
  assign pos        = KW'(count) - KW'(1) - digit_slot;
  assign glyph      = is_minus ? MINUS_GLYPH : digits[pos[IW-1:0]];
  assign font_idx   = 8'(glyph) * 8'(GLYPH_BITS) + 8'(row) * 8'(GLYPH_W) + 8'(sub);
  assign font_bit   = (font_idx < 8'(FONT_LEN)) ? FONT_ROM[font_idx] : 1'b0;

  always_comb begin
    priority if (outside) begin
      pixel_class = CLS_BLANK;
    end else if (sub == 2'(GLYPH_W)) begin
      pixel_class = CLS_BACKGROUND;
    end else if (is_minus || in_digits) begin
      pixel_class = font_bit ? CLS_FOREGROUND : CLS_BACKGROUND;
    end else begin
      pixel_class = CLS_BLANK;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/signed_integer_digit_glyph_renderer.sv */
// Signed integer glyph renderer. A pixel query is answered in the cycle after
// its beat is taken, so queries can stream one per cycle while the block is idle
// and results are accepted. A set-value beat holds the block while it works out
// the digits it keeps (1 to MAX_DIGITS; up to six at the default): each digit takes
// one pass through the shared reciprocal multiplier and one digit step to peel off
// the remainder, all steered by a four-step microprogram. Results wait
// in a single output register; while a result sits there unaccepted, no new
// beat is taken and a finished set-value holds in its last step.
`default_nettype none
`include "signed_integer_digit_glyph_renderer_defines.svh"

module signed_integer_digit_glyph_renderer #(
  parameter int MAX_DIGITS = 6
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  sigr_pkg::sigr_in_t   in_data,
  output logic                 out_valid,
  input  wire                  out_ready,
  output sigr_pkg::sigr_out_t  out_data
);
  import sigr_pkg::*;

  localparam int CW = $clog2(MAX_DIGITS + 1);
  localparam int WW = $clog2(MAX_DIGITS * 4 + 5);

  step_t     step_r, step_nxt;
  logic      out_valid_r;
  sigr_out_t out_data_r;

  ucode_t    uc;
  dp_ctrl_t  ctrl;
  logic      out_free;
  logic      in_fire;
  logic      query_fire;
  logic      cond_true;

  logic                       neg;
  logic [MAX_DIGITS-1:0][3:0] digits;
  logic [CW-1:0]              count;
  logic [WW-1:0]              width;
  logic                       digits_done;
  logic [WW-1:0]              fin_width;
  logic                       fin_shrink;
  logic                       shrink;
  logic [1:0]                 pixel_class;

  sigr_ucode_rom u_rom (
    .step (step_r),
    .word (uc)
  );

  assign out_free   = !out_valid_r || out_ready;
  assign in_ready   = uc.accept_en && out_free;
  assign in_fire    = in_valid && in_ready;
  assign query_fire = in_fire && (in_data.opcode == OP_QUERY);

  always_comb begin
    unique case (uc.cond)
      COND_NEVER:       cond_true = 1'b0;
      COND_START:       cond_true = in_fire && (in_data.opcode == OP_SET);
      COND_DIGITS_DONE: cond_true = digits_done;
      COND_OUT_FREE:    cond_true = out_free;
      default:          cond_true = 1'b0;
    endcase
  end

  assign step_nxt = cond_true ? uc.jump_step : uc.next_step;

  assign ctrl = '{load:   in_fire && (in_data.opcode == OP_SET),
                  mul:    uc.mul_en,
                  digit:  uc.digit_en,
                  finish: uc.finish_en && out_free};

  sigr_digit_path #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .load_value  (in_data.new_value),
    .neg         (neg),
    .digits      (digits),
    .count       (count),
    .width       (width),
    .shrink      (shrink),
    .digits_done (digits_done),
    .fin_width   (fin_width),
    .fin_shrink  (fin_shrink)
  );

  sigr_pixel_lookup #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_px (
    .row         (in_data.pixel_row),
    .col         (in_data.pixel_column),
    .neg         (neg),
    .digits      (digits),
    .count       (count),
    .width       (width),
    .pixel_class (pixel_class)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (query_fire) begin
        out_valid_r <= 1'b1;
        out_data_r  <= '{pixel_class:  pixel_class,
                         drawn_width:  5'(width),
                         area_reduced: shrink};
      end else if (ctrl.finish) begin
        out_valid_r <= 1'b1;
        out_data_r  <= '{pixel_class:  CLS_BACKGROUND,
                         drawn_width:  5'(fin_width),
                         area_reduced: fin_shrink};
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `SIGR_ASSERT_IMP(a_ready_only_idle, clk, rst_n, in_ready, step_r == STEP_IDLE,
                   "beat taken while the digit loop is busy")
  `SIGR_ASSERT_NXT(a_finish_result, clk, rst_n, ctrl.finish,
                   out_valid_r && (step_r == STEP_IDLE) &&
                   (out_data_r.pixel_class == CLS_BACKGROUND),
                   "set-value finish did not yield a result")
  `SIGR_ASSERT_NXT(a_query_width, clk, rst_n, query_fire,
                   out_valid_r && (out_data_r.drawn_width == $past(5'(width))),
                   "query result width differs from stored width")

endmodule

`default_nettype wire

/* dv/sigr_glyph_checker.sv */
`timescale 1ns / 1ps
// Glyph renderer checker: follows the displayed value from set-value beats,
// predicts each result beat and compares it with the output channel.
// Depends on sigr_pkg.
module sigr_glyph_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  sigr_pkg::sigr_in_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  sigr_pkg::sigr_out_t out_data,
  output int                  mismatches,
  output int                  outstanding
);
  import sigr_pkg::*;

  localparam int DIGITS_KEPT = 6;
  localparam int FONT_BITS   = 168;
  // digits 0..9 then minus, 15 bits per glyph, byte k at [8k+7:8k]
  localparam logic [FONT_BITS-1:0] GLYPH_FONT = {
    8'd0, 8'd112, 8'd36, 8'd247, 8'd251, 8'd239, 8'd146, 8'd79, 8'd239, 8'd39, 8'd206,
    8'd124, 8'd158, 8'd223, 8'd60, 8'd252, 8'd249, 8'd250, 8'd73, 8'd251, 8'd111
  };

  logic       shown_neg;
  logic [3:0] shown_digits [DIGITS_KEPT];
  int         shown_count;
  logic [4:0] shown_width;
  logic       shrunk;
  sigr_out_t  pending_results [$];
  int         bad = 0;

  function automatic logic font_pixel(int glyph, int row, int sub);
    int idx;
    idx = glyph * GLYPH_BITS + row * GLYPH_W + sub;
    return (idx < FONT_BITS) ? GLYPH_FONT[idx] : 1'b0;
  endfunction

  task automatic render_beat(input sigr_in_t beat, output sigr_out_t res);
    logic [31:0] mag;
    int          w;
    int          row;
    int          col;
    int          slot;
    int          sub;
    logic [1:0]  cls;
    if (beat.opcode == OP_SET) begin
      shown_neg = beat.new_value[31];
      mag = beat.new_value;
      // two's complement negate also covers the most negative value exactly
      if (shown_neg) mag = 32'd0 - mag;
      shown_digits[0] = 4'(mag % 10);
      shown_count = 1;
      while (mag > 9 && shown_count < DIGITS_KEPT) begin
        mag = mag / 10;
        shown_digits[shown_count] = 4'(mag % 10);
        shown_count++;
      end
      w = shown_count * SLOT_W - 1 + (shown_neg ? SLOT_W : 0);
      shrunk = (w < shown_width);
      shown_width = 5'(w);
      cls = CLS_BACKGROUND;
    end else begin
      row = beat.pixel_row;
      col = beat.pixel_column;
      if (col >= shown_width || row >= GLYPH_H) begin
        cls = CLS_BLANK;
      end else begin
        slot = col / SLOT_W;
        sub  = col % SLOT_W;
        if (sub == GLYPH_W) begin
          cls = CLS_BACKGROUND;
        end else if (shown_neg && slot == 0) begin
          cls = font_pixel(MINUS_GLYPH, row, sub) ? CLS_FOREGROUND : CLS_BACKGROUND;
        end else begin
          if (shown_neg) slot--;
          // leftmost slot holds the most significant kept digit
          if (slot < shown_count) begin
            cls = font_pixel(shown_digits[shown_count - 1 - slot], row, sub) ?
                  CLS_FOREGROUND : CLS_BACKGROUND;
          end else begin
            cls = CLS_BLANK;
          end
        end
      end
    end
    res.pixel_class  = cls;
    res.drawn_width  = shown_width;
    res.area_reduced = shrunk;
  endtask

  always @(posedge clk) begin : watch
    sigr_out_t predicted;
    if (!rst_n) begin
      shown_neg   = 1'b0;
      shown_count = 0;
      shown_width = '0;
      shrunk      = 1'b0;
      for (int i = 0; i < DIGITS_KEPT; i++) shown_digits[i] = '0;
      pending_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        render_beat(in_data, predicted);
        pending_results.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with none expected: class %0d width %0d reduced %0d",
                   $time, out_data.pixel_class, out_data.drawn_width, out_data.area_reduced);
          bad++;
        end else begin
          predicted = pending_results.pop_front();
          if (out_data !== predicted) begin
            $display("%0t: expected class %0d width %0d reduced %0d, got %0d %0d %0d",
                     $time, predicted.pixel_class, predicted.drawn_width,
                     predicted.area_reduced, out_data.pixel_class, out_data.drawn_width,
                     out_data.area_reduced);
            bad++;
          end
        end
      end
    end
    mismatches  <= bad;
    outstanding <= pending_results.size();
  end

endmodule

/* dv/signed_integer_digit_glyph_renderer_tb.sv */
`timescale 1ns / 1ps
// Top of the glyph renderer testbench: clock, reset, directed and random beats
// under idle/stall phases, and the verdict.
// Depends on sigr_pkg, the renderer RTL and sigr_glyph_checker.
module signed_integer_digit_glyph_renderer_tb;
  import sigr_pkg::*;

  localparam int RANDOM_BEATS = 1350;
  localparam int CYCLE_LIMIT  = 400000;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  sigr_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  sigr_out_t out_data;
  int        mismatches;
  int        outstanding;
  int        cycle_count = 0;
  int        idle_pct    = 0;
  int        stall_pct   = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  signed_integer_digit_glyph_renderer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  sigr_glyph_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_ready   <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // unused fields of a beat still carry random bits
  function automatic sigr_in_t filler_beat();
    sigr_in_t b;
    b.opcode       = 1'($urandom);
    b.new_value    = $urandom;
    b.pixel_row    = 3'($urandom);
    b.pixel_column = 5'($urandom);
    return b;
  endfunction

  task automatic send_beat(input sigr_in_t beat);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_value(input logic [31:0] value);
    sigr_in_t b;
    b = filler_beat();
    b.opcode    = OP_SET;
    b.new_value = value;
    send_beat(b);
  endtask

  task automatic send_query(input int row, input int col);
    sigr_in_t b;
    b = filler_beat();
    b.opcode       = OP_QUERY;
    b.pixel_row    = 3'(row);
    b.pixel_column = 5'(col);
    send_beat(b);
  endtask

  // mostly values of a random digit count, some corners and raw words
  function automatic logic [31:0] pick_value();
    longint span;
    longint v;
    int     k;
    case ($urandom_range(9))
      0: return $urandom;
      1: begin
        case ($urandom_range(5))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'd0;
          3:       return 32'hFFFF_FFFF;
          4:       return 32'd999999;
          default: return 32'd1000000;
        endcase
      end
      default: begin
        span = 1;
        k = $urandom_range(1, 10);
        repeat (k) span = span * 10;
        v = longint'($urandom) % span;
        if ($urandom_range(1) == 1) v = -v;
        return v[31:0];
      end
    endcase
  endfunction

  initial begin : stimulus
    int sent;
    int n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // nothing set yet: every pixel blank
    send_query(0, 0);
    send_query(7, 31);
    // most negative value keeps 483648 behind a minus
    send_value(32'h8000_0000);
    send_query(0, 0);
    send_query(2, 1);
    send_query(4, 3);
    send_query(4, 26);
    send_query(5, 4);
    send_query(7, 5);
    send_value(32'h7FFF_FFFF);
    send_query(0, 22);
    send_query(0, 23);
    send_query(3, 31);
    send_value(32'd0);
    send_query(4, 2);
    send_query(1, 3);
    send_value(32'hFFFF_FFFF);
    send_value(32'd1234567);
    send_value(32'd999999);
    send_value(-32'sd999999);
    send_query(2, 9);
    send_value(32'd10);
    send_query(1, 4);
    send_query(3, 6);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 68; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      sent = 0;
      while (sent < RANDOM_BEATS / 4) begin
        if ($urandom_range(9) < 8) begin
          // a new value, then a run of pixel reads over it
          send_value(pick_value());
          n = $urandom_range(2, 8);
          repeat (n) begin
            send_query(($urandom_range(99) < 85) ? $urandom_range(4) : $urandom_range(7),
                       ($urandom_range(99) < 85) ? $urandom_range(27) : $urandom_range(31));
          end
          sent += n + 1;
        end else begin
          send_beat(filler_beat());
          sent++;
        end
      end
    end
    in_valid <= 1'b0;
    // let the checker count the last beat before draining
    @(posedge clk);

    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("signed_integer_digit_glyph_renderer_tb: PASS");
    end else begin
      $display("signed_integer_digit_glyph_renderer_tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("signed_integer_digit_glyph_renderer_tb: FAIL");
    $finish;
  end

endmodule
